// ----- design/assert_macros.svh -----
// Assertion macros shared by the beat interval rate averager RTL.
// Each macro expects clk_i and rst_ni to be visible in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication checked on every clock edge outside of reset.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- design/bira_pkg.sv -----
// Package for the beat interval rate averager: widths, constants, FSM and
// divider handshake types. No dependencies.
package bira_pkg;

  localparam int unsigned TPM_W      = 24;
  localparam int unsigned INTERVAL_W = 32;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned AVG_SHIFT  = 3;
  localparam int unsigned RATE_AVG_W = RATE_W - AVG_SHIFT;
  localparam int unsigned STEP_CNT_W = $clog2(TPM_W);

  localparam logic [TPM_W-1:0]      TPM_RESET = TPM_W'(7500000);
  localparam logic [RATE_W-1:0]     ZERO_RATE = {RATE_W{1'b1}};
  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(TPM_W - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_ACC
  } state_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- design/bira_divider.sv -----
// Restoring divider, one quotient bit per cycle, 24-bit dividend by 32-bit
// divisor. Depends on bira_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bira_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bira_pkg::div_ctrl_t             ctrl_i,
  input  logic [bira_pkg::TPM_W-1:0]      dividend_i,
  input  logic [bira_pkg::INTERVAL_W-1:0] divisor_i,
  output bira_pkg::div_stat_t             stat_o,
  output logic [bira_pkg::TPM_W-1:0]      quotient_o
);

  logic                                busy_q, done_q;
  logic [bira_pkg::STEP_CNT_W-1:0]     cnt_q;
  logic [bira_pkg::TPM_W-1:0]          dvd_q;
  logic [bira_pkg::INTERVAL_W-1:0]     dvs_q, rem_q, rem_d;
  logic [bira_pkg::INTERVAL_W:0]       shifted, diff;
  logic                                q_bit;

  assign shifted = {rem_q, dvd_q[bira_pkg::TPM_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign q_bit   = (shifted >= {1'b0, dvs_q});
  assign rem_d   = q_bit ? diff[bira_pkg::INTERVAL_W-1:0]
                         : shifted[bira_pkg::INTERVAL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == bira_pkg::LAST_STEP) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[bira_pkg::TPM_W-2:0], q_bit};
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = dvd_q;

  `ASSERT_IMPLY(a_done_one_cycle, done_q, !busy_q && !$past(done_q),
                "Divider done is not a single pulse after the last step.")

endmodule

// ----- design/beat_interval_rate_averager.sv -----
// Top level of the beat interval rate averager: sequencer, accumulator and
// output register. Depends on bira_pkg, bira_divider and assert_macros.svh.
//
// Usage: each request on the input channel (in_valid_i/in_ready_o) carries
// one beat interval in timer ticks. The block divides ticks_per_minute by it
// in a restoring divider that produces one quotient bit per cycle,
// and adds the low 16 bits of the quotient to a wrapping 16-bit sum. A zero
// interval skips the divider, adds 65535 and marks the group.
// After every BEATS_AVERAGED-th request one result request leaves on the
// output channel (out_valid_o/out_ready_i): the sum shifted right by three
// and the zero-interval mark. The sum, count and mark then clear.
// Sequence: a nonzero interval starts the divider, waits in S_DIV through
// its 24 steps until done, then accumulates in S_ACC; a zero interval goes
// straight to S_ACC. in_ready_o is low while an item is in work.
// A result sits in an output register, so a stalled receiver only holds the
// block when a further group completes before the previous result is taken.
// The configuration channel (cfg_valid_i/cfg_ready_o) is always ready and
// writes ticks_per_minute; write it only while the block is idle.
// Reset sets ticks_per_minute to 7500000 and clears sum, count and mark.
`include "assert_macros.svh"

module beat_interval_rate_averager #(
  parameter int unsigned BEATS_AVERAGED = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bira_pkg::TPM_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bira_pkg::INTERVAL_W-1:0] interval_ticks_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bira_pkg::RATE_AVG_W-1:0] rate_average_o,
  output logic                            zero_interval_seen_o
);

  localparam int unsigned CNT_W = $clog2(BEATS_AVERAGED);
  localparam logic [CNT_W-1:0] LAST_BEAT = CNT_W'(BEATS_AVERAGED - 1);

  bira_pkg::state_e state_q, state_d;
  bira_pkg::div_ctrl_t div_ctrl;
  bira_pkg::div_stat_t div_stat;

  logic [bira_pkg::TPM_W-1:0]      tpm_q, quotient;
  logic [CNT_W-1:0]                beat_cnt_q, beat_cnt_d;
  logic [bira_pkg::RATE_W-1:0]     rate_sum_q, rate_sum_d, rate_q, rate_d, sum_new;
  logic                            zero_flag_q, zero_flag_d;
  logic                            out_valid_q, out_valid_d;
  logic [bira_pkg::RATE_AVG_W-1:0] rate_average_q;
  logic                            zero_seen_q;
  logic                            in_accept, out_load, last_beat;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == bira_pkg::S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign sum_new     = rate_sum_q + rate_q;
  assign last_beat   = (beat_cnt_q == LAST_BEAT);

  bira_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (tpm_q),
    .divisor_i  (interval_ticks_i),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d        = state_q;
    beat_cnt_d     = beat_cnt_q;
    rate_sum_d     = rate_sum_q;
    rate_d         = rate_q;
    zero_flag_d    = zero_flag_q;
    div_ctrl.start = 1'b0;
    out_load       = 1'b0;
    case (state_q)
      bira_pkg::S_IDLE: begin
        if (in_accept) begin
          if (interval_ticks_i == '0) begin
            rate_d      = bira_pkg::ZERO_RATE;
            zero_flag_d = 1'b1;
            state_d     = bira_pkg::S_ACC;
          end else begin
            div_ctrl.start = 1'b1;
            state_d        = bira_pkg::S_DIV;
          end
        end
      end
      bira_pkg::S_DIV: begin
        if (div_stat.done) begin
          rate_d  = quotient[bira_pkg::RATE_W-1:0];
          state_d = bira_pkg::S_ACC;
        end
      end
      bira_pkg::S_ACC: begin
        if (!last_beat) begin
          rate_sum_d = sum_new;
          beat_cnt_d = beat_cnt_q + 1'b1;
          state_d    = bira_pkg::S_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          rate_sum_d  = '0;
          beat_cnt_d  = '0;
          zero_flag_d = 1'b0;
          state_d     = bira_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bira_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bira_pkg::S_IDLE;
      tpm_q       <= bira_pkg::TPM_RESET;
      beat_cnt_q  <= '0;
      rate_sum_q  <= '0;
      zero_flag_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      beat_cnt_q  <= beat_cnt_d;
      rate_sum_q  <= rate_sum_d;
      zero_flag_q <= zero_flag_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tpm_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rate_q <= rate_d;
    if (out_load) begin
      rate_average_q <= sum_new[bira_pkg::RATE_W-1:bira_pkg::AVG_SHIFT];
      zero_seen_q    <= zero_flag_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign rate_average_o       = rate_average_q;
  assign zero_interval_seen_o = zero_seen_q;

  `ASSERT_IMPLY(a_start_when_free, div_ctrl.start, !div_stat.busy,
                "Divider started while a division is still running.")
  `ASSERT_IMPLY(a_done_in_div, div_stat.done, state_q == bira_pkg::S_DIV,
                "Divider finished while the sequencer was not waiting for it.")
  `ASSERT_IMPLY(a_no_result_overwrite, out_valid_q && !out_ready_i, !out_load,
                "A waiting result was overwritten by a new one.")
  `ASSERT_PROP(a_count_range, beat_cnt_q <= LAST_BEAT,
               "Beat count left its range.")

endmodule
